/* rtl/core/bsrt_pkg.sv */
// Package for the buffer status report trigger.
// Holds transaction types, event and format codes, controller state and
// the command and status structs between controller and datapath.
package bsrt_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int IDX_W        = $clog2(NUM_CHANNELS);

    // Event codes carried in req_type
    localparam logic [2:0] REQ_OCC   = 3'd0;
    localparam logic [2:0] REQ_STEP  = 3'd1;
    localparam logic [2:0] REQ_PER   = 3'd2;
    localparam logic [2:0] REQ_RETX  = 3'd3;
    localparam logic [2:0] REQ_GRANT = 3'd4;
    localparam logic [2:0] REQ_SR    = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_GROUP_MAP = 2'd0;
    localparam logic [1:0] CFG_PRIO_MAP  = 2'd1;
    localparam logic [1:0] CFG_PER_LEN   = 2'd2;
    localparam logic [1:0] CFG_RETX_LEN  = 2'd3;

    typedef enum logic [1:0] {
        TRIG_NONE     = 2'd0,
        TRIG_REGULAR  = 2'd1,
        TRIG_PERIODIC = 2'd2,
        TRIG_PADDING  = 2'd3
    } t_trig;

    typedef enum logic [1:0] {
        FMT_SHORT = 2'd0,
        FMT_LONG  = 2'd1,
        FMT_TRUNC = 2'd2
    } t_fmt;

    typedef enum logic [1:0] {
        TCMD_NONE    = 2'd0,
        TCMD_START   = 2'd1,
        TCMD_RESTART = 2'd2
    } t_tcmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SUM,
        ST_P1,
        ST_APPLY,
        ST_P2,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  channel;
        logic [23:0] pending_bits;
        logic [15:0] grant_bytes;
        logic [15:0] padding_bytes;
    } t_in_item;

    typedef struct packed {
        logic        send_report;
        logic [1:0]  report_format;
        logic [23:0] group_bytes_0;
        logic [23:0] group_bytes_1;
        logic [23:0] group_bytes_2;
        logic [23:0] group_bytes_3;
        logic        send_sr;
        logic [1:0]  periodic_timer_cmd;
        logic [1:0]  retx_timer_cmd;
    } t_out_item;

    typedef struct packed {
        logic             load;
        logic             clr_sum;
        logic             clr_scan;
        logic             sum_step;
        logic             p1_step;
        logic             apply_single;
        logic             p2_step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } t_bsrt_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       trig_none;
        logic       pad_ge2;
        logic       out_free;
    } t_bsrt_sts;

endpackage

/* rtl/core/bsrt_ctrl.sv */
// Controller of the buffer status report trigger.
// Sequences the channel walks for each transaction; uses bsrt_pkg.
module bsrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bsrt_pkg::t_bsrt_sts i_sts,
    output logic                o_in_stall,
    output bsrt_pkg::t_bsrt_cmd o_cmd
);

    localparam logic [bsrt_pkg::IDX_W-1:0] LAST_IDX =
        bsrt_pkg::IDX_W'(bsrt_pkg::NUM_CHANNELS - 1);

    bsrt_pkg::t_state              r_state, n_state;
    logic [bsrt_pkg::IDX_W-1:0]    r_idx, n_idx;

    // State and walk index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsrt_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_stall = (r_state != bsrt_pkg::ST_IDLE);
        unique case (r_state)
            bsrt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bsrt_pkg::ST_START;
                end
            end
            bsrt_pkg::ST_START: begin
                n_idx   = '0;
                n_state = bsrt_pkg::ST_FINISH;
                priority case (i_sts.req)
                    bsrt_pkg::REQ_STEP: begin
                        o_cmd.clr_scan = 1'b1;
                        n_state        = bsrt_pkg::ST_P1;
                    end
                    bsrt_pkg::REQ_PER: begin
                        if (i_sts.trig_none) begin
                            o_cmd.clr_sum = 1'b1;
                            n_state       = bsrt_pkg::ST_SUM;
                        end
                    end
                    bsrt_pkg::REQ_RETX: begin
                        o_cmd.clr_sum = 1'b1;
                        n_state       = bsrt_pkg::ST_SUM;
                    end
                    bsrt_pkg::REQ_GRANT: begin
                        if (i_sts.trig_none && i_sts.pad_ge2) begin
                            o_cmd.clr_sum = 1'b1;
                            n_state       = bsrt_pkg::ST_SUM;
                        end
                    end
                    default: ;
                endcase
            end
            bsrt_pkg::ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                n_idx          = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = bsrt_pkg::ST_FINISH;
                end
            end
            bsrt_pkg::ST_P1: begin
                o_cmd.p1_step = 1'b1;
                n_idx         = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = bsrt_pkg::ST_APPLY;
                end
            end
            bsrt_pkg::ST_APPLY: begin
                o_cmd.apply_single = 1'b1;
                n_idx              = '0;
                n_state            = bsrt_pkg::ST_P2;
            end
            bsrt_pkg::ST_P2: begin
                o_cmd.p2_step = 1'b1;
                n_idx         = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = bsrt_pkg::ST_FINISH;
                end
            end
            bsrt_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = bsrt_pkg::ST_IDLE;
                end
            end
            default: n_state = bsrt_pkg::ST_IDLE;
        endcase
    end

endmodule

/* rtl/core/bsrt_dp.sv */
// Datapath of the buffer status report trigger.
// Holds configuration, channel occupancy, group sums, trigger state and the
// output register; acts on bsrt_ctrl commands. Uses bsrt_pkg.
module bsrt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsrt_pkg::t_bsrt_cmd i_cmd,
    output bsrt_pkg::t_bsrt_sts o_sts,
    input  bsrt_pkg::t_in_item  i_in,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsrt_pkg::t_out_item o_out
);

    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    // Configuration
    logic [23:0] r_group_map;
    logic [31:0] r_prio_map;
    logic [15:0] r_per_len;
    logic [15:0] r_retx_len;

    // Block state
    logic [23:0]          r_occ [bsrt_pkg::NUM_CHANNELS];
    logic [23:0]          r_size [4];
    bsrt_pkg::t_trig      r_trig;
    logic                 r_sr_sent;
    logic                 r_per_run;
    logic                 r_retx_run;

    // Transaction and walk scratch
    bsrt_pkg::t_in_item   r_item;
    logic                 r_scanned;
    logic                 r_any;
    logic [1:0]           r_cnt;
    logic [20:0]          r_hit_bytes;
    logic [1:0]           r_hit_grp;
    logic [3:0]           r_maxp;
    logic                 r_found;

    bsrt_pkg::t_out_item  r_out;
    logic                 r_out_valid;

    function automatic logic [2:0] grp_field(input logic [23:0] gm,
                                             input logic [bsrt_pkg::IDX_W-1:0] c);
        return gm[3*c +: 3];
    endfunction

    function automatic logic [3:0] prio_of(input logic [31:0] pm,
                                           input logic [bsrt_pkg::IDX_W-1:0] c);
        return pm[4*c +: 4];
    endfunction

    // Highest priority channel, lowest index on ties
    function automatic logic [bsrt_pkg::IDX_W-1:0] top_chan(input logic [31:0] pm);
        logic [bsrt_pkg::IDX_W-1:0] best;
        logic [3:0]                 bp;
        best = '0;
        bp   = '0;
        for (int c = 0; c < bsrt_pkg::NUM_CHANNELS; c++) begin
            if (pm[4*c +: 4] > bp) begin
                bp   = pm[4*c +: 4];
                best = bsrt_pkg::IDX_W'(c);
            end
        end
        return best;
    endfunction

    // Current walk channel
    logic [2:0]  w_gf;
    logic [23:0] w_occ;
    logic [20:0] w_bytes;
    logic [3:0]  w_prio;
    logic [24:0] w_sum;

    always_comb begin
        w_gf    = grp_field(r_group_map, i_cmd.idx);
        w_occ   = r_occ[i_cmd.idx];
        w_bytes = w_occ[23:3];
        w_prio  = prio_of(r_prio_map, i_cmd.idx);
        w_sum   = {1'b0, r_size[w_gf[1:0]]} + 25'(w_bytes);
    end

    // Grant evaluation
    bsrt_pkg::t_trig             w_eff_trig;
    logic [2:0]                  w_nlcg;
    logic [25:0]                 w_total;
    bsrt_pkg::t_fmt              w_fmt;
    logic [25:0]                 w_hdr;
    logic                        w_send;
    logic [bsrt_pkg::IDX_W-1:0]  w_top;
    logic [2:0]                  w_top_gf;
    logic [23:0]                 w_rsz [4];

    always_comb begin
        w_eff_trig = (r_scanned && r_any) ? bsrt_pkg::TRIG_PADDING : r_trig;
        w_nlcg     = '0;
        w_total    = '0;
        for (int g = 0; g < 4; g++) begin
            w_total = w_total + 26'(r_size[g]);
            w_nlcg  = w_nlcg + 3'(r_size[g] != '0);
        end
        w_top    = top_chan(r_prio_map);
        w_top_gf = grp_field(r_group_map, w_top);
        if (w_eff_trig == bsrt_pkg::TRIG_PADDING) begin
            if (r_item.padding_bytes < 16'd4) begin
                w_fmt = (w_nlcg > 3'd1) ? bsrt_pkg::FMT_TRUNC : bsrt_pkg::FMT_SHORT;
            end else begin
                w_fmt = bsrt_pkg::FMT_LONG;
            end
        end else begin
            w_fmt = (w_nlcg > 3'd1) ? bsrt_pkg::FMT_LONG : bsrt_pkg::FMT_SHORT;
        end
        for (int g = 0; g < 4; g++) begin
            if (w_fmt == bsrt_pkg::FMT_TRUNC &&
                (!w_top_gf[2] || w_top_gf[1:0] != 2'(g))) begin
                w_rsz[g] = '0;
            end else begin
                w_rsz[g] = r_size[g];
            end
        end
        w_hdr  = (w_fmt == bsrt_pkg::FMT_LONG) ? 26'd4 : 26'd2;
        w_send = ((w_total + w_hdr) != {10'd0, r_item.grant_bytes});
    end

    // Result of the transaction being closed
    bsrt_pkg::t_out_item w_res;

    always_comb begin
        w_res = '0;
        unique case (r_item.req_type)
            bsrt_pkg::REQ_STEP: begin
                if (!r_per_run && r_per_len != '0) begin
                    w_res.periodic_timer_cmd = bsrt_pkg::TCMD_START;
                end
                if (!r_retx_run && r_retx_len != '0) begin
                    w_res.retx_timer_cmd = bsrt_pkg::TCMD_START;
                end
            end
            bsrt_pkg::REQ_GRANT: begin
                if (w_eff_trig != bsrt_pkg::TRIG_NONE && w_send) begin
                    w_res.send_report   = 1'b1;
                    w_res.report_format = w_fmt;
                    w_res.group_bytes_0 = w_rsz[0];
                    w_res.group_bytes_1 = w_rsz[1];
                    w_res.group_bytes_2 = w_rsz[2];
                    w_res.group_bytes_3 = w_rsz[3];
                    if (r_per_run && w_fmt != bsrt_pkg::FMT_TRUNC) begin
                        w_res.periodic_timer_cmd = bsrt_pkg::TCMD_RESTART;
                    end
                end
                if (r_retx_run) w_res.retx_timer_cmd = bsrt_pkg::TCMD_RESTART;
            end
            bsrt_pkg::REQ_SR: begin
                if (!r_sr_sent && r_trig == bsrt_pkg::TRIG_REGULAR) begin
                    w_res.send_sr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.req       = r_item.req_type;
    assign o_sts.trig_none = (r_trig == bsrt_pkg::TRIG_NONE);
    assign o_sts.pad_ge2   = (r_item.padding_bytes >= 16'd2);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_map <= '0;
            r_prio_map  <= '0;
            r_per_len   <= '0;
            r_retx_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsrt_pkg::CFG_GROUP_MAP: r_group_map <= i_cfg_data[23:0];
                bsrt_pkg::CFG_PRIO_MAP:  r_prio_map  <= i_cfg_data;
                bsrt_pkg::CFG_PER_LEN:   r_per_len   <= i_cfg_data[15:0];
                bsrt_pkg::CFG_RETX_LEN:  r_retx_len  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
    end

    // Block state, walks and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < bsrt_pkg::NUM_CHANNELS; c++) r_occ[c] <= '0;
            for (int g = 0; g < 4; g++) r_size[g] <= '0;
            r_trig      <= bsrt_pkg::TRIG_NONE;
            r_sr_sent   <= 1'b0;
            r_per_run   <= 1'b0;
            r_retx_run  <= 1'b0;
            r_scanned   <= 1'b0;
            r_any       <= 1'b0;
            r_cnt       <= '0;
            r_maxp      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on a new result, drop it once the result is taken
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_scanned <= 1'b0;
            end
            if (i_cmd.clr_sum) begin
                for (int g = 0; g < 4; g++) r_size[g] <= '0;
                r_any     <= 1'b0;
                r_scanned <= 1'b1;
            end
            if (i_cmd.clr_scan) begin
                r_cnt   <= '0;
                r_maxp  <= '0;
                r_found <= 1'b0;
            end
            // Accumulate reported bytes per group, saturating
            if (i_cmd.sum_step && w_gf[2]) begin
                r_size[w_gf[1:0]] <= w_sum[24] ? MAX24 : w_sum[23:0];
                if (w_bytes != '0) r_any <= 1'b1;
            end
            // First pass: single candidate and top priority among busy channels
            if (i_cmd.p1_step) begin
                if (w_gf[2] && w_occ != '0) begin
                    r_hit_bytes <= w_bytes;
                    r_hit_grp   <= w_gf[1:0];
                    if (r_cnt != 2'd2) r_cnt <= r_cnt + 1'b1;
                end
                if (w_occ != '0 && w_prio > r_maxp) r_maxp <= w_prio;
            end
            if (i_cmd.apply_single && r_trig == bsrt_pkg::TRIG_NONE && r_cnt == 2'd1) begin
                r_size[r_hit_grp] <= 24'(r_hit_bytes);
                r_trig            <= bsrt_pkg::TRIG_REGULAR;
            end
            // Second pass: first unbeaten reported channel with bytes
            if (i_cmd.p2_step && !r_found && w_gf[2] && w_bytes != '0 &&
                w_prio >= r_maxp) begin
                r_size[w_gf[1:0]] <= 24'(w_bytes);
                r_trig            <= bsrt_pkg::TRIG_REGULAR;
                r_found           <= 1'b1;
            end
            // Close the transaction and load the result
            if (i_cmd.finish) begin
                r_out <= w_res;
                unique case (r_item.req_type)
                    bsrt_pkg::REQ_OCC: begin
                        r_occ[r_item.channel] <= r_item.pending_bits;
                    end
                    bsrt_pkg::REQ_STEP: begin
                        if (!r_per_run && r_per_len != '0) r_per_run <= 1'b1;
                        if (!r_retx_run && r_retx_len != '0) r_retx_run <= 1'b1;
                    end
                    bsrt_pkg::REQ_PER: begin
                        if (r_scanned && r_any) r_trig <= bsrt_pkg::TRIG_PERIODIC;
                    end
                    bsrt_pkg::REQ_RETX: begin
                        if (r_any) begin
                            r_trig    <= bsrt_pkg::TRIG_REGULAR;
                            r_sr_sent <= 1'b0;
                        end
                    end
                    bsrt_pkg::REQ_GRANT: begin
                        if (w_eff_trig != bsrt_pkg::TRIG_NONE) begin
                            for (int g = 0; g < 4; g++) r_size[g] <= w_rsz[g];
                            r_trig <= bsrt_pkg::TRIG_NONE;
                        end
                    end
                    bsrt_pkg::REQ_SR: begin
                        if (!r_sr_sent && r_trig == bsrt_pkg::TRIG_REGULAR) begin
                            r_sr_sent <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

/* rtl/core/buffer_status_report_trigger.sv */
// Each transaction runs from accept through START to FINISH; events that sum
// the groups add the SUM walk, and a slot step adds the P1 walk, APPLY and P2;
// each walk over the eight channels takes one channel a cycle in the datapath.
// Throughput: one transaction at a time; the next is taken the cycle after the
// result is loaded into the output register, which holds it while stalled.
// Reset (synchronous, active low) clears configuration, occupancy and state.
module buffer_status_report_trigger (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsrt_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsrt_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    bsrt_pkg::t_bsrt_cmd w_cmd;
    bsrt_pkg::t_bsrt_sts w_sts;

    bsrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    bsrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // Hold off a new transaction right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("transaction accepted while previous one still in flight");

    // Clear report fields when no report is sent
    a_no_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.send_report) |->
        (o_out.report_format == 2'd0 && o_out.group_bytes_0 == 24'd0 &&
         o_out.group_bytes_1 == 24'd0 && o_out.group_bytes_2 == 24'd0 &&
         o_out.group_bytes_3 == 24'd0))
        else $error("report fields set without a report");

    // Never restart the periodic timer on a truncated report
    a_trunc_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.report_format == bsrt_pkg::FMT_TRUNC) |->
        (o_out.periodic_timer_cmd == bsrt_pkg::TCMD_NONE))
        else $error("periodic restart with truncated report");
`endif

endmodule

/* tb/tb_buffer_status_report_trigger.sv */
// Self-checking testbench for buffer_status_report_trigger.
// Drives events through a bursty valid/stall sender and checks every result
// against a predictor of its own; depends only on bsrt_pkg and the block.
module tb_buffer_status_report_trigger;

    localparam int N_RANDOM = 750;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    bsrt_pkg::t_in_item  i_in = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    bsrt_pkg::t_out_item o_out;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = bsrt_pkg::CFG_GROUP_MAP;
    logic [31:0]         i_cfg_data = '0;

    buffer_status_report_trigger dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state and configuration copy
    logic [23:0]     occ [bsrt_pkg::NUM_CHANNELS];
    logic [23:0]     grp_sum [4];
    bsrt_pkg::t_trig trig_kind;
    bit              sr_done, per_run, retx_run;
    logic [23:0]     grp_map_r;
    logic [31:0]     prio_map_r;
    logic [15:0]     per_len_r, retx_len_r;

    bsrt_pkg::t_out_item pending_reports [$];
    int                  mismatches = 0;
    bit                  want_hold = 1'b0;

    function automatic bit lc_reported(int c);
        return grp_map_r[3*c+2];
    endfunction

    function automatic int lc_group(int c);
        return int'(grp_map_r[3*c +: 2]);
    endfunction

    function automatic int lc_prio(int c);
        return int'(prio_map_r[4*c +: 4]);
    endfunction

    // Rebuild the per-group byte sums; return whether any group holds bytes
    function automatic bit sum_groups();
        bit          any = 1'b0;
        logic [24:0] s;
        for (int g = 0; g < 4; g++) grp_sum[g] = '0;
        for (int c = 0; c < bsrt_pkg::NUM_CHANNELS; c++) begin
            if (lc_reported(c)) begin
                s = grp_sum[lc_group(c)] + (occ[c] >> 3);
                grp_sum[lc_group(c)] = s[24] ? 24'hFFFFFF : s[23:0];
                if ((occ[c] >> 3) != 0) any = 1'b1;
            end
        end
        return any;
    endfunction

    // Advance the predictor by one event and return the expected result
    function automatic bsrt_pkg::t_out_item predict_report(bsrt_pkg::t_in_item it);
        bsrt_pkg::t_out_item r;
        int                  hit, cnt, nlcg, top, bp;
        int                  total;
        bit                  beaten, found, rep;
        bsrt_pkg::t_fmt      fmt;
        r = '0;
        case (it.req_type)
            bsrt_pkg::REQ_OCC: occ[it.channel] = it.pending_bits;
            bsrt_pkg::REQ_STEP: begin
                if (!per_run && per_len_r != 0) begin
                    per_run = 1'b1;
                    r.periodic_timer_cmd = bsrt_pkg::TCMD_START;
                end
                if (!retx_run && retx_len_r != 0) begin
                    retx_run = 1'b1;
                    r.retx_timer_cmd = bsrt_pkg::TCMD_START;
                end
                if (trig_kind == bsrt_pkg::TRIG_NONE) begin
                    hit = 0;
                    cnt = 0;
                    for (int c = 0; c < bsrt_pkg::NUM_CHANNELS; c++)
                        if (lc_reported(c) && occ[c] != 0) begin
                            hit = c;
                            cnt++;
                        end
                    if (cnt == 1) begin
                        grp_sum[lc_group(hit)] = occ[hit] >> 3;
                        trig_kind = bsrt_pkg::TRIG_REGULAR;
                    end
                end
                found = 1'b0;
                for (int i = 0; i < bsrt_pkg::NUM_CHANNELS; i++) begin
                    if (!found && lc_reported(i) && (occ[i] >> 3) != 0) begin
                        beaten = 1'b0;
                        for (int j = 0; j < bsrt_pkg::NUM_CHANNELS; j++)
                            if (occ[j] != 0 && lc_prio(j) > lc_prio(i)) beaten = 1'b1;
                        if (!beaten) begin
                            grp_sum[lc_group(i)] = occ[i] >> 3;
                            trig_kind = bsrt_pkg::TRIG_REGULAR;
                            found = 1'b1;
                        end
                    end
                end
            end
            bsrt_pkg::REQ_PER: begin
                if (trig_kind == bsrt_pkg::TRIG_NONE && sum_groups())
                    trig_kind = bsrt_pkg::TRIG_PERIODIC;
            end
            bsrt_pkg::REQ_RETX: begin
                if (sum_groups()) begin
                    trig_kind = bsrt_pkg::TRIG_REGULAR;
                    sr_done = 1'b0;
                end
            end
            bsrt_pkg::REQ_GRANT: begin
                if (trig_kind == bsrt_pkg::TRIG_NONE && it.padding_bytes >= 2 && sum_groups())
                    trig_kind = bsrt_pkg::TRIG_PADDING;
                if (trig_kind != bsrt_pkg::TRIG_NONE) begin
                    total = 0;
                    nlcg = 0;
                    for (int g = 0; g < 4; g++) begin
                        total += int'(grp_sum[g]);
                        if (grp_sum[g] != 0) nlcg++;
                    end
                    if (trig_kind == bsrt_pkg::TRIG_PADDING) begin
                        if (it.padding_bytes < 4) begin
                            if (nlcg > 1) begin
                                // truncate to the group of the top-priority channel
                                top = 0;
                                bp = 0;
                                for (int c = 0; c < 8; c++)
                                    if (lc_prio(c) > bp) begin
                                        bp = lc_prio(c);
                                        top = c;
                                    end
                                rep = lc_reported(top);
                                fmt = bsrt_pkg::FMT_TRUNC;
                                for (int g = 0; g < 4; g++)
                                    if (!rep || lc_group(top) != g) grp_sum[g] = '0;
                            end else begin
                                fmt = bsrt_pkg::FMT_SHORT;
                            end
                        end else begin
                            fmt = bsrt_pkg::FMT_LONG;
                        end
                    end else begin
                        fmt = nlcg > 1 ? bsrt_pkg::FMT_LONG : bsrt_pkg::FMT_SHORT;
                    end
                    if (total + (fmt == bsrt_pkg::FMT_LONG ? 4 : 2) != int'(it.grant_bytes))
                    begin
                        r.send_report   = 1'b1;
                        r.report_format = fmt;
                        r.group_bytes_0 = grp_sum[0];
                        r.group_bytes_1 = grp_sum[1];
                        r.group_bytes_2 = grp_sum[2];
                        r.group_bytes_3 = grp_sum[3];
                        if (per_run && fmt != bsrt_pkg::FMT_TRUNC)
                            r.periodic_timer_cmd = bsrt_pkg::TCMD_RESTART;
                    end
                    trig_kind = bsrt_pkg::TRIG_NONE;
                end
                if (retx_run) r.retx_timer_cmd = bsrt_pkg::TCMD_RESTART;
            end
            bsrt_pkg::REQ_SR: begin
                if (!sr_done && trig_kind == bsrt_pkg::TRIG_REGULAR) begin
                    sr_done = 1'b1;
                    r.send_sr = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bsrt_pkg::t_in_item mk_item(logic [2:0] req, logic [2:0] ch,
                                                   logic [23:0] bits, logic [15:0] grant,
                                                   logic [15:0] pad);
        bsrt_pkg::t_in_item it;
        it.req_type      = req;
        it.channel       = ch;
        it.pending_bits  = bits;
        it.grant_bytes   = grant;
        it.padding_bytes = pad;
        return it;
    endfunction

    // Random event, weighted towards updates, steps and grants
    function automatic bsrt_pkg::t_in_item rand_event();
        bsrt_pkg::t_in_item it;
        int                 w, total;
        logic [23:0]        bits;
        logic [15:0]        grant, pad;
        it = mk_item(3'($urandom), 3'($urandom), 24'($urandom), 16'($urandom),
                     16'($urandom));
        w = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
            0: bits = 24'd0;
            1: bits = 24'($urandom_range(1, 7));
            2: bits = 24'($urandom_range(8, 4000));
            3: bits = 24'hFFFFFF - 24'($urandom_range(0, 15));
            default: bits = 24'($urandom);
        endcase
        total = 0;
        for (int g = 0; g < 4; g++) total += int'(grp_sum[g]);
        case ($urandom_range(0, 4))
            0: grant = 16'(total + 2);
            1: grant = 16'(total + 4);
            default: grant = 16'($urandom);
        endcase
        pad = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        if (w < 8) return it;
        it.pending_bits  = bits;
        it.grant_bytes   = grant;
        it.padding_bytes = pad;
        if (w < 40) it.req_type = bsrt_pkg::REQ_OCC;
        else if (w < 60) it.req_type = bsrt_pkg::REQ_STEP;
        else if (w < 67) it.req_type = bsrt_pkg::REQ_PER;
        else if (w < 74) it.req_type = bsrt_pkg::REQ_RETX;
        else if (w < 92) it.req_type = bsrt_pkg::REQ_GRANT;
        else it.req_type = bsrt_pkg::REQ_SR;
        return it;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_event(bsrt_pkg::t_in_item it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_reports.push_back(predict_report(it));
    endtask

    // Drop valid and wait for every outstanding result, plus the scan latency
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic set_config(logic [23:0] gm, logic [31:0] pm,
                              logic [15:0] pl, logic [15:0] rl);
        logic [31:0] vals [4];
        vals = '{32'(gm), pm, 32'(pl), 32'(rl)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b0;
        grp_map_r  = gm;
        prio_map_r = pm;
        per_len_r  = pl;
        retx_len_r = rl;
    endtask

    task automatic check_field(string fname, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", fname, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        bsrt_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out);
            end else begin
                e = pending_reports.pop_front();
                check_field("send_report", 24'(e.send_report), 24'(o_out.send_report));
                check_field("report_format", 24'(e.report_format),
                            24'(o_out.report_format));
                check_field("group_bytes_0", e.group_bytes_0, o_out.group_bytes_0);
                check_field("group_bytes_1", e.group_bytes_1, o_out.group_bytes_1);
                check_field("group_bytes_2", e.group_bytes_2, o_out.group_bytes_2);
                check_field("group_bytes_3", e.group_bytes_3, o_out.group_bytes_3);
                check_field("send_sr", 24'(e.send_sr), 24'(o_out.send_sr));
                check_field("periodic_timer_cmd", 24'(e.periodic_timer_cmd),
                            24'(o_out.periodic_timer_cmd));
                check_field("retx_timer_cmd", 24'(e.retx_timer_cmd),
                            24'(o_out.retx_timer_cmd));
            end
        end
    end

    // Receiver: stall pattern changes among three random modes; long hold on request
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            for (int k = 0; k < 64; k++) begin
                @(posedge i_clk);
                if (want_hold) begin
                    want_hold = 1'b0;
                    i_out_stall <= 1'b1;
                    for (int h = 0; h < 300; h++) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= (mode == 0) ? 1'b0 :
                                   (mode == 1) ? ($urandom_range(0, 3) == 0) :
                                                 ($urandom_range(0, 3) != 0);
                end
            end
        end
    end

    // Hard limit on run time
    initial begin
        #(12 * 600000);
        $display("*** FAILED ***");
        $finish;
    end

    typedef struct {
        bsrt_pkg::t_in_item  item;
        bit                  typed;
        bsrt_pkg::t_out_item want;
    } t_dir_row;

    initial begin
        t_dir_row            rows [$];
        t_dir_row            row;
        bsrt_pkg::t_out_item got_exp;
        int                  gap;
        int                  burst;

        // Predictor reset
        for (int c = 0; c < bsrt_pkg::NUM_CHANNELS; c++) occ[c] = '0;
        for (int g = 0; g < 4; g++) grp_sum[g] = '0;
        trig_kind = bsrt_pkg::TRIG_NONE;
        sr_done = 1'b0; per_run = 1'b0; retx_run = 1'b0;
        grp_map_r = '0; prio_map_r = '0; per_len_r = '0; retx_len_r = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration, results all zero at a glance
        row.typed = 1'b1;
        row.want  = '0;
        row.item = mk_item(bsrt_pkg::REQ_STEP, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'hFFFF, 16'hFFFF);
        rows.push_back(row);
        row.item = mk_item(3'd6, 3'd7, 24'hFFFFFF, 16'hFFFF, 16'hFFFF); rows.push_back(row);
        row.item = mk_item(3'd7, 3'd5, 24'h5A5A5A, 16'h1234, 16'd3);    rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_SR, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd7, 24'hFFFFFF, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd7, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        foreach (rows[n]) begin
            send_event(rows[n].item);
            got_exp = pending_reports[$];
            if (got_exp !== rows[n].want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: expected %h, predicted %h",
                             n, rows[n].want, got_exp);
            end
        end
        wait_idle();

        // Directed: every channel reported (groups 2,3,2,2,1,1,3,3 for channels 0-7), priority c
        set_config(24'hFEDCBA & 24'hFFFFFF | 24'h924924, 32'h76543210, 16'd40, 16'd80);
        rows.delete();
        row.typed = 1'b0;
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd0, 24'hFFFFFF, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_STEP, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_SR, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_SR, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'd100, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd1, 24'd5, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd6, 24'd800, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd4, 24'hFFFFFF, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_RETX, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'd1, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_PER, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'd9, 16'd2);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'd9, 16'd3);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_GRANT, 3'd0, 24'd0, 16'hFFFF, 16'd4);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd4, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_OCC, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        row.item = mk_item(bsrt_pkg::REQ_STEP, 3'd0, 24'd0, 16'd0, 16'd0);
        rows.push_back(row);
        foreach (rows[n]) send_event(rows[n].item);
        wait_idle();

        // Random phases under several configurations, extremes first
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
                1: set_config(24'h000000, 32'h00000000, 16'h0000, 16'h0000);
                2: set_config(24'hFFFFFF, 32'h01234567, 16'd1, 16'd0);
                default: set_config(24'($urandom) | 24'h924924 & 24'($urandom), $urandom,
                                    $urandom_range(0, 1) ? 16'($urandom) : 16'd0,
                                    $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
            endcase
            burst = 0;
            for (int n = 0; n < N_RANDOM / 6; n++) begin
                if (ph == 2 && n == 20) want_hold = 1'b1;
                send_event(rand_event());
                if (burst > 0) begin
                    burst--;
                end else begin
                    burst = $urandom_range(0, 12);
                    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
                    if (gap > 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
